### hw/rtl/tae_pkg.sv
// Shared constants and a function for the tilt angle estimator.
package tae_pkg;

  localparam int ZW = 25;
  localparam logic signed [ZW-1:0] Z_HALF_TURN = 25'sd2949120;
  localparam logic signed [14:0] ANG_LIMIT = 15'sd11520;
  localparam logic [8:0] WEIGHT_RESET = 9'd13;
  localparam logic [8:0] WEIGHT_MAX = 9'd256;
  localparam logic REG_FILTER_WEIGHT = 1'b0;

  function automatic logic [19:0] atan_val(input logic [4:0] i);
    logic [19:0] v;
    unique case (i)
      5'd0: v = 20'd737280;
      5'd1: v = 20'd435242;
      5'd2: v = 20'd229970;
      5'd3: v = 20'd116736;
      5'd4: v = 20'd58595;
      5'd5: v = 20'd29326;
      5'd6: v = 20'd14667;
      5'd7: v = 20'd7334;
      5'd8: v = 20'd3667;
      5'd9: v = 20'd1833;
      5'd10: v = 20'd917;
      5'd11: v = 20'd458;
      5'd12: v = 20'd229;
      5'd13: v = 20'd115;
      5'd14: v = 20'd57;
      5'd15: v = 20'd29;
      5'd16: v = 20'd14;
      5'd17: v = 20'd7;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      5'd20: v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/tae_cordic_cell.sv
// One vectoring CORDIC iteration with its output register.
module tae_cordic_cell #(
  parameter int IDX = 0,
  parameter int W = 27
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic signed [W-1:0]       x_i,
  input  logic signed [W-1:0]       y_i,
  input  logic signed [tae_pkg::ZW-1:0] z_i,
  output logic                      vld_o,
  output logic signed [W-1:0]       x_o,
  output logic signed [W-1:0]       y_o,
  output logic signed [tae_pkg::ZW-1:0] z_o
);

  logic signed [W-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [tae_pkg::ZW-1:0] ang, z_nxt;
  logic vld_r;
  logic signed [W-1:0] x_r, y_r;
  logic signed [tae_pkg::ZW-1:0] z_r;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    ang = $signed({5'd0, tae_pkg::atan_val(5'(IDX))});
    if (!y_i[W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ang;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign vld_o = vld_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

### hw/rtl/tilt_angle_estimator.sv
// Top level of the tilt angle estimator: two CORDIC cell rows, filters and gyro integrals.
// An accepted input item passes through the CORDIC cell rows, the angle registers and the output register.
// Only one item is in flight: a new item is not accepted until the previous one has finished.
// A new item is accepted while the previous result waits in the output register.
// Synchronous active-low reset clears filter and gyro state and sets the weight to 13.
module tilt_angle_estimator #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ms
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pitch_meas, roll_meas, pitch_smooth, roll_smooth, pitch_integral, roll_integral, pad
  output logic [159:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int W = SAMPLE_BITS + 11;
  localparam int ZW = tae_pkg::ZW;

  logic [8:0] weight_r;
  logic busy_r, pend_r, out_valid_r;
  logic [159:0] out_data_r;
  logic signed [23:0] pacc_r, racc_r;
  logic signed [47:0] psum_r, rsum_r;
  logic signed [32:0] pprod_r, rprod_r;
  logic pzero_r, rzero_r;
  logic signed [14:0] pang_r, rang_r;

  logic accept, cfg_wr, finish;
  assign accept = in_tvalid && in_tready;
  assign in_tready = !busy_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tae_pkg::REG_FILTER_WEIGHT) ? {23'd0, weight_r} : 32'd0;

  logic signed [SAMPLE_BITS-1:0] ax_s, ay_s, az_s;
  generate
    if (SAMPLE_BITS <= 16) begin : g_narrow
      assign ax_s = in_tdata[SAMPLE_BITS-1:0];
      assign ay_s = in_tdata[16+SAMPLE_BITS-1:16];
      assign az_s = in_tdata[32+SAMPLE_BITS-1:32];
    end else begin : g_wide
      assign ax_s = SAMPLE_BITS'(in_tdata[15:0]);
      assign ay_s = SAMPLE_BITS'(in_tdata[31:16]);
      assign az_s = SAMPLE_BITS'(in_tdata[47:32]);
    end
  endgenerate

  logic signed [W-1:0] axw, ayw, azw;
  logic signed [W-1:0] px0, py0, rx0, ry0;
  logic signed [ZW-1:0] pz0, rz0;
  logic zneg;

  always_comb begin
    axw = W'(ax_s) <<< 8;
    ayw = W'(ay_s) <<< 8;
    azw = W'(az_s) <<< 8;
    zneg = azw[W-1];
    px0 = zneg ? -azw : azw;
    rx0 = px0;
    py0 = zneg ? -axw : axw;
    ry0 = zneg ? -ayw : ayw;
    pz0 = '0;
    rz0 = '0;
    if (zneg) begin
      pz0 = axw[W-1] ? -tae_pkg::Z_HALF_TURN : tae_pkg::Z_HALF_TURN;
      rz0 = ayw[W-1] ? -tae_pkg::Z_HALF_TURN : tae_pkg::Z_HALF_TURN;
    end
  end

  logic                 pv [CORDIC_STEPS+1];
  logic                 rv [CORDIC_STEPS+1];
  logic signed [W-1:0]  pxc [CORDIC_STEPS+1];
  logic signed [W-1:0]  pyc [CORDIC_STEPS+1];
  logic signed [ZW-1:0] pzc [CORDIC_STEPS+1];
  logic signed [W-1:0]  rxc [CORDIC_STEPS+1];
  logic signed [W-1:0]  ryc [CORDIC_STEPS+1];
  logic signed [ZW-1:0] rzc [CORDIC_STEPS+1];

  assign pv[0] = accept;
  assign rv[0] = accept;
  assign pxc[0] = px0;
  assign pyc[0] = py0;
  assign pzc[0] = pz0;
  assign rxc[0] = rx0;
  assign ryc[0] = ry0;
  assign rzc[0] = rz0;

  genvar g;
  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      tae_cordic_cell #(.IDX(g), .W(W)) u_pcell (
        .clk, .rst_n, .vld_i(pv[g]), .x_i(pxc[g]), .y_i(pyc[g]), .z_i(pzc[g]),
        .vld_o(pv[g+1]), .x_o(pxc[g+1]), .y_o(pyc[g+1]), .z_o(pzc[g+1])
      );
      tae_cordic_cell #(.IDX(g), .W(W)) u_rcell (
        .clk, .rst_n, .vld_i(rv[g]), .x_i(rxc[g]), .y_i(ryc[g]), .z_i(rzc[g]),
        .vld_o(rv[g+1]), .x_o(rxc[g+1]), .y_o(ryc[g+1]), .z_o(rzc[g+1])
      );
    end
  endgenerate

  function automatic logic signed [14:0] round_clamp(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    logic signed [ZW-9:0] s;
    t = z + ZW'(128);
    s = t[ZW-1:8];
    if (s > (ZW-8)'(tae_pkg::ANG_LIMIT)) return tae_pkg::ANG_LIMIT;
    if (s < -(ZW-8)'(tae_pkg::ANG_LIMIT)) return -tae_pkg::ANG_LIMIT;
    return s[14:0];
  endfunction

  logic signed [14:0] pang_nxt, rang_nxt;
  always_comb begin
    pang_nxt = pzero_r ? 15'sd0 : -round_clamp(pzc[CORDIC_STEPS]);
    rang_nxt = rzero_r ? 15'sd0 : round_clamp(rzc[CORDIC_STEPS]);
  end

  assign finish = pend_r && (!out_valid_r || out_tready);

  logic [8:0] w_eff;
  logic signed [24:0] pdiff, rdiff;
  logic signed [34:0] pmul, rmul;
  logic signed [23:0] pacc_nxt, racc_nxt;
  logic signed [23:0] pround, rround;
  logic signed [48:0] psum_w, rsum_w;
  logic signed [47:0] psum_nxt, rsum_nxt;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    return v[47:0];
  endfunction

  always_comb begin
    w_eff = (weight_r > tae_pkg::WEIGHT_MAX) ? tae_pkg::WEIGHT_MAX : weight_r;
    pdiff = (25'(pang_r) <<< 8) - 25'(pacc_r);
    rdiff = (25'(rang_r) <<< 8) - 25'(racc_r);
    pmul = 35'($signed({1'b0, w_eff})) * 35'(pdiff);
    rmul = 35'($signed({1'b0, w_eff})) * 35'(rdiff);
    pacc_nxt = pacc_r + 24'(pmul >>> 8);
    racc_nxt = racc_r + 24'(rmul >>> 8);
    pround = (pacc_nxt + 24'sd128) >>> 8;
    rround = (racc_nxt + 24'sd128) >>> 8;
    psum_w = 49'(psum_r) + 49'(pprod_r);
    rsum_w = 49'(rsum_r) + 49'(rprod_r);
    psum_nxt = sat48(psum_w);
    rsum_nxt = sat48(rsum_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= tae_pkg::WEIGHT_RESET;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      pacc_r <= '0;
      racc_r <= '0;
      psum_r <= '0;
      rsum_r <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == tae_pkg::REG_FILTER_WEIGHT) begin
        weight_r <= cfg_pwdata[8:0];
      end
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (pv[CORDIC_STEPS]) begin
        pend_r <= 1'b1;
      end
      if (finish) begin
        pend_r <= 1'b0;
        busy_r <= 1'b0;
        out_valid_r <= 1'b1;
        pacc_r <= pacc_nxt;
        racc_r <= racc_nxt;
        psum_r <= psum_nxt;
        rsum_r <= rsum_nxt;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      pzero_r <= (ax_s == '0) && (az_s == '0);
      rzero_r <= (ay_s == '0) && (az_s == '0);
      pprod_r <= 33'($signed(in_tdata[79:64])) * 33'($signed({1'b0, in_tdata[95:80]}));
      rprod_r <= 33'($signed(in_tdata[63:48])) * 33'($signed({1'b0, in_tdata[95:80]}));
    end
    if (pv[CORDIC_STEPS]) begin
      pang_r <= pang_nxt;
      rang_r <= rang_nxt;
    end
    if (finish) begin
      out_data_r <= {4'd0, rsum_nxt, psum_nxt, rround[14:0], pround[14:0], rang_r, pang_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

### hw/rtl/tae_checker.sv
// Port-level checker for the tilt angle estimator, bound to the top level.
module tae_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic         cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Output item changed while stalled.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("Input accepted while an item is in flight.");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("Output item appeared one cycle after accept.");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("Configuration port not ready.");

endmodule

bind tilt_angle_estimator tae_checker u_tae_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_pready
);
